@@ src/lkt_pkg.sv @@
// lkt_pkg: shared types, codes and sizes for the two-party lock table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lkt_pkg;

  localparam int LOCK_COUNT = 16;
  localparam int IDX_W      = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int CMD_W      = 3;
  localparam int ID_W       = 4;
  localparam int STS_W      = 2;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ID_W-1:0]  lock_id_t;
  typedef logic [STS_W-1:0] status_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LOCK_COUNT-1:0] lock_vec_t;

  localparam cmd_t CMD_CREATE  = 3'd0;
  localparam cmd_t CMD_ACQUIRE = 3'd1;
  localparam cmd_t CMD_CHECK   = 3'd2;
  localparam cmd_t CMD_RELEASE = 3'd3;
  localparam cmd_t CMD_DESTROY = 3'd4;

  localparam status_t STS_OK       = 2'd0;
  localparam status_t STS_INACTIVE = 2'd1;
  localparam status_t STS_FULL     = 2'd2;

  typedef struct packed {
    logic exec;
  } lkt_ctl_t;

endpackage

`default_nettype wire

@@ src/lkt_req_if.sv @@
// lkt_req_if: request channel (cmd, lock_id, role) with valid/ready
// depends on lkt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lkt_req_if;
  import lkt_pkg::*;

  logic     valid;
  logic     ready;
  cmd_t     cmd;
  lock_id_t lock_id;
  logic     role;

  modport source (output valid, output cmd, output lock_id, output role, input ready);
  modport sink (input valid, input cmd, input lock_id, input role, output ready);

endinterface

`default_nettype wire

@@ src/lkt_rsp_if.sv @@
// lkt_rsp_if: response channel (status, new_lock, granted) with valid/ready
// depends on lkt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface lkt_rsp_if;
  import lkt_pkg::*;

  logic     valid;
  logic     ready;
  status_t  status;
  lock_id_t new_lock;
  logic     granted;

  modport source (output valid, output status, output new_lock, output granted, input ready);
  modport sink (input valid, input status, input new_lock, input granted, output ready);

endinterface

`default_nettype wire

@@ src/lkt_ctrl.sv @@
// lkt_ctrl: handshake controller, tracks the response register occupancy
// depends on lkt_pkg
`timescale 1ns / 1ps
`default_nettype none

module lkt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output lkt_pkg::lkt_ctl_t     ctl
);
  import lkt_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready   = (state == ST_EMPTY) || out_ready;
    out_valid  = (state == ST_FULL);
    ctl.exec   = in_valid && in_ready;
    state_next = state;
    if (ctl.exec) begin
      state_next = ST_FULL;
    end else if (out_ready) begin
      state_next = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !in_valid) |=> out_valid)
    else $error("response dropped before taken");

endmodule

`default_nettype wire

@@ src/lkt_dp.sv @@
// lkt_dp: lock table state, command execution and response register
// depends on lkt_pkg
`timescale 1ns / 1ps
`default_nettype none

module lkt_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lkt_pkg::lkt_ctl_t ctl,
  input  wire lkt_pkg::cmd_t     cmd,
  input  wire lkt_pkg::lock_id_t lock_id,
  input  wire logic              role,
  output lkt_pkg::status_t       status,
  output lkt_pkg::lock_id_t      new_lock,
  output logic                   granted
);
  import lkt_pkg::*;

  lock_vec_t active;
  lock_vec_t intent0;
  lock_vec_t intent1;
  lock_vec_t turn;
  lock_vec_t active_next;
  lock_vec_t intent0_next;
  lock_vec_t intent1_next;
  lock_vec_t turn_next;

  status_t  status_next;
  lock_id_t new_lock_next;
  logic     granted_next;

  idx_t idx;
  idx_t free_idx;
  logic free_found;
  logic in_range;
  logic hit;
  logic other_flag;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = LOCK_COUNT - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    idx        = IDX_W'(lock_id);
    in_range   = (int'(lock_id) < LOCK_COUNT);
    hit        = in_range && active[idx];
    other_flag = role ? intent0[idx] : intent1[idx];

    active_next   = active;
    intent0_next  = intent0;
    intent1_next  = intent1;
    turn_next     = turn;
    status_next   = STS_OK;
    new_lock_next = '0;
    granted_next  = 1'b0;

    unique case (cmd)
      CMD_CREATE: begin
        if (free_found) begin
          active_next[free_idx] = 1'b1;
          new_lock_next         = ID_W'(free_idx);
        end else begin
          status_next = STS_FULL;
        end
      end
      CMD_ACQUIRE: begin
        if (hit) begin
          if (role) begin
            intent1_next[idx] = 1'b1;
          end else begin
            intent0_next[idx] = 1'b1;
          end
          turn_next[idx] = role;
          granted_next   = !other_flag;
        end else begin
          status_next = STS_INACTIVE;
        end
      end
      CMD_CHECK: begin
        if (hit) begin
          granted_next = !(other_flag && (turn[idx] == role));
        end else begin
          status_next = STS_INACTIVE;
        end
      end
      CMD_RELEASE: begin
        if (hit) begin
          if (role) begin
            intent1_next[idx] = 1'b0;
          end else begin
            intent0_next[idx] = 1'b0;
          end
        end else begin
          status_next = STS_INACTIVE;
        end
      end
      CMD_DESTROY: begin
        if (hit) begin
          active_next[idx]  = 1'b0;
          intent0_next[idx] = 1'b0;
          intent1_next[idx] = 1'b0;
          turn_next[idx]    = 1'b0;
        end else begin
          status_next = STS_INACTIVE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= '0;
      intent0 <= '0;
      intent1 <= '0;
      turn    <= '0;
    end else if (ctl.exec) begin
      active  <= active_next;
      intent0 <= intent0_next;
      intent1 <= intent1_next;
      turn    <= turn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status   <= status_next;
      new_lock <= new_lock_next;
      granted  <= granted_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    ((intent0 | intent1 | turn) & ~active) == '0)
    else $error("lock state on inactive entry");

  assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && cmd == CMD_CREATE && free_found) |=> active[$past(free_idx)])
    else $error("create did not claim entry");

  assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && cmd != CMD_CREATE && !hit)
      |=> ($stable(active) && $stable(intent0) && $stable(intent1) && $stable(turn)))
    else $error("miss changed lock state");

  assert property (@(posedge clk) disable iff (rst)
    (ctl.exec && cmd == CMD_CREATE && !free_found) |=> (active == '1))
    else $error("full report with free entry");

endmodule

`default_nettype wire

@@ src/two_party_lock_table.sv @@
// two_party_lock_table: top level, table of two-party Peterson locks
// depends on lkt_pkg, lkt_req_if, lkt_rsp_if, lkt_ctrl, lkt_dp
//
//   channel  dir  payload                      handshake
//   req      in   cmd[2:0] lock_id[3:0] role   valid/ready
//   rsp      out  status[1:0] new_lock[3:0]    valid/ready
//                 granted
//
// one request per cycle while rsp.ready is high; each response is registered and appears in the cycle after its request
// the lock table is flip-flops, updated in the accepting cycle together with
// the priority encode of the lowest free entry
// rst clears all entries at once, no sweep
// a held response stalls requests only while rsp.ready is low
`timescale 1ns / 1ps
`default_nettype none

module two_party_lock_table (
  input wire logic clk,
  input wire logic rst,
  lkt_req_if.sink  req,
  lkt_rsp_if.source rsp
);
  import lkt_pkg::*;

  lkt_ctl_t ctl;

  lkt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl)
  );

  lkt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .cmd      (req.cmd),
    .lock_id  (req.lock_id),
    .role     (req.role),
    .status   (rsp.status),
    .new_lock (rsp.new_lock),
    .granted  (rsp.granted)
  );

endmodule

`default_nettype wire
